// ===== hdl/rtdc_pkg.sv =====
package rtdc_pkg;

   localparam int FRACTION_BITS = 8;

   localparam int CODE_W  = 15;
   localparam int RES_W   = 21;
   localparam int OFF_W   = 16;
   localparam int TEMP_W  = 19;
   localparam int PROD_W  = CODE_W + RES_W;       // code * rref
   localparam int NUM_W   = PROD_W + 15;          // scaled by 2^15
   localparam int QUOT_W  = 34;                   // quotient bits kept
   localparam int DIV_W   = RES_W + QUOT_W + 1;   // trial divisor width
   localparam int XQ_W    = 34;                   // ratio, Q30, up to 8.0
   localparam int RAD_W   = 56;
   localparam int ROOT_W  = 28;
   localparam int U_W     = 30;
   localparam int H_W     = 36;
   localparam int XS_W    = 30;                   // ratio below 1.0
   localparam int POLY_N  = 5;
   localparam int RW      = 72;                   // rounding helper width

   localparam logic [XQ_W-1:0] X_ONE = XQ_W'(64'd1 << 30);
   localparam logic [XQ_W-1:0] X_MAX = XQ_W'(64'd8 << 30);

   localparam logic signed [63:0] CVD_P  = 64'sd221761341;
   localparam logic signed [63:0] CVD_C  = 64'sd6926407;
   localparam logic signed [63:0] CVD_P2 = CVD_P * CVD_P;

   localparam logic signed [H_W-1:0] POLY_C5 = H_W'(64'sd25573510);

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

   typedef struct packed {
      logic [15:0] raw_code;
      logic [7:0]  fault_status;
   } req_payload_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic                     fault_flag;
      logic [7:0]               fault_code;
   } rsp_payload_type;

   typedef struct packed {
      logic       fault_flag;
      logic [7:0] fault_code;
   } tag_type;

   typedef struct packed {
      logic            valid;
      tag_type         tag;
      logic [XQ_W-1:0] xq;
   } x_stage_type;

   typedef struct packed {
      logic                  valid;
      tag_type               tag;
      logic [XQ_W-1:0]       xq;
      logic signed [U_W-1:0] u;
   } u_stage_type;

   typedef struct packed {
      logic                  valid;
      tag_type               tag;
      logic signed [U_W-1:0] u;
      logic signed [H_W-1:0] h;
   } h_stage_type;

   // Horner coefficients, Q24, applied after each multiply (c4 first)
   function automatic logic signed [H_W-1:0] poly_coef(input int j);
      logic signed [63:0] c;
      case (j)
         0:       c = -64'sd47283228;
         1:       c = -64'sd80966844;
         2:       c = 64'sd433842029;
         3:       c = 64'sd3729239572;
         default: c = -64'sd4060421816;
      endcase
      return H_W'(c);
   endfunction

   // shift right, round to nearest, halves away from zero
   function automatic logic signed [RW-1:0] round_shr(input logic signed [RW-1:0] v,
                                                       input int n);
      logic [RW-1:0] half;
      logic [RW-1:0] mag;
      half = (n == 0) ? '0 : (RW'(1) << (n - 1));
      if (v >= 0) begin
         mag = (RW'(v) + half) >> n;
         return $signed(mag);
      end
      mag = (RW'(0) - RW'(v) + half) >> n;
      return $signed(RW'(0) - mag);
   endfunction

endpackage

// ===== hdl/rtd_code_to_temperature_unit.sv =====
// RTD code to temperature converter, Callendar-Van Dusen for platinum sensors.
// Input: a transaction is taken at each clock edge with start high and busy
//   low; req_payload carries the converter word and the fault status byte.
//   busy never rises, so one transaction can enter every cycle.
// Output: rsp_valid strobes for one cycle with rsp_payload holding the
//   temperature (1/256 C, saturated), fault flag and fault code. The receiver
//   cannot stall; every result is taken in the cycle it is shown.
// Throughput: one per cycle. The pipeline is made of the ratio divider (one
//   quotient bit per stage, 34 stages), the square root (one root bit per
//   stage, 28 stages) and the five Horner multiply/add stage pairs of the
//   below-zero polynomial.
// Configuration: csr_write_enable writes csr_write_data into register
//   csr_index (0 reference resistance, 1 nominal resistance, 2 offset).
//   Other indexes are ignored. Write only while no transaction is in flight.
// Reset: synchronous, clears the pipeline valid bits and restores the
//   register defaults; no result strobes until new transactions arrive.
module rtd_code_to_temperature_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  rtdc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   output rtdc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [20:0]               csr_write_data
);
   import rtdc_pkg::*;

   typedef enum logic [1:0] {
      CSR_REF_RES = 2'd0,
      CSR_NOM_RES = 2'd1,
      CSR_OFFSET  = 2'd2
   } csr_index_type;

   logic [RES_W-1:0]        ref_res_ff;
   logic [RES_W-1:0]        nom_res_ff;
   logic signed [OFF_W-1:0] offset_ff;
   logic [RES_W-1:0]        nom_eff;

   x_stage_type x_stage;
   u_stage_type u_stage;
   h_stage_type h_stage;

   logic signed [39:0]       t_round;
   logic signed [40:0]       t_sum;
   logic signed [TEMP_W-1:0] t_sat;
   logic                     rsp_valid_ff;
   rsp_payload_type          rsp_payload_ff;

   // pipeline always accepts
   assign busy = 1'b0;

   // zero nominal resistance is treated as one LSB
   assign nom_eff = (nom_res_ff == '0) ? RES_W'(1) : nom_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_res_ff <= RES_W'(110080);
         nom_res_ff <= RES_W'(25600);
         offset_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REF_RES: ref_res_ff <= csr_write_data;
            CSR_NOM_RES: nom_res_ff <= csr_write_data;
            CSR_OFFSET:  offset_ff  <= csr_write_data[OFF_W-1:0];
            default: ;
         endcase
      end
   end

   rtdc_ratio_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy),
      .in_payload (req_payload),
      .ref_res    (ref_res_ff),
      .nom_res    (nom_eff),
      .x_out      (x_stage)
   );

   rtdc_cvd_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .x_in  (x_stage),
      .u_out (u_stage)
   );

   rtdc_poly u_poly (
      .clock (clock),
      .reset (reset),
      .u_in  (u_stage),
      .h_out (h_stage)
   );

   // quadratic result unless it went below zero, then the polynomial
   always_comb begin
      if (h_stage.u >= 0) begin
         t_round = 40'(round_shr(RW'(h_stage.u), 16 - FRACTION_BITS));
      end else begin
         t_round = 40'(round_shr(RW'(h_stage.h), 24 - FRACTION_BITS));
      end
      t_sum = 41'(t_round) + 41'(offset_ff);
      if (t_sum > 41'(TEMP_MAX)) begin
         t_sat = TEMP_MAX;
      end else if (t_sum < 41'(TEMP_MIN)) begin
         t_sat = TEMP_MIN;
      end else begin
         t_sat = TEMP_W'(t_sum);
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff               <= h_stage.valid;
      rsp_payload_ff.temperature <= t_sat;
      rsp_payload_ff.fault_flag  <= h_stage.tag.fault_flag;
      rsp_payload_ff.fault_code  <= h_stage.tag.fault_code;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== hdl/rtdc_ratio_div.sv =====
module rtdc_ratio_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  rtdc_pkg::req_payload_type in_payload,
   input  logic [20:0]               ref_res,
   input  logic [20:0]               nom_res,
   output rtdc_pkg::x_stage_type     x_out
);
   import rtdc_pkg::*;

   // multiply stage
   logic              m_valid_ff;
   tag_type           m_tag_ff;
   logic [PROD_W-1:0] m_prod_ff;
   // overflow check stage
   logic              o_valid_ff;
   tag_type           o_tag_ff;
   logic [NUM_W-1:0]  o_num_ff;
   logic              o_ovf_ff;
   // one quotient bit per stage
   logic              d_valid_ff [QUOT_W+1];
   tag_type           d_tag_ff   [QUOT_W+1];
   logic              d_ovf_ff   [QUOT_W+1];
   logic [NUM_W-1:0]  d_rem_ff   [QUOT_W+1];
   logic [QUOT_W-1:0] d_q_ff     [QUOT_W+1];
   logic [NUM_W-1:0]  d_rem_in   [QUOT_W];
   logic [QUOT_W-1:0] d_q_in     [QUOT_W];
   logic [XQ_W-1:0]   xq_in;
   x_stage_type       x_ff;

   always_comb begin
      for (int s = 0; s < QUOT_W; s++) begin
         logic [DIV_W-1:0] trial;
         logic [DIV_W-1:0] remx;
         trial = DIV_W'(nom_res) << (QUOT_W - 1 - s);
         remx  = DIV_W'(d_rem_ff[s]);
         if (remx >= trial) begin
            d_rem_in[s] = NUM_W'(remx - trial);
            d_q_in[s]   = d_q_ff[s] | (QUOT_W'(1) << (QUOT_W - 1 - s));
         end else begin
            d_rem_in[s] = d_rem_ff[s];
            d_q_in[s]   = d_q_ff[s];
         end
      end
   end

   always_comb begin
      if (d_ovf_ff[QUOT_W] || (d_q_ff[QUOT_W] > X_MAX)) begin
         xq_in = X_MAX;
      end else begin
         xq_in = d_q_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      m_valid_ff          <= in_valid;
      m_tag_ff.fault_flag <= in_payload.raw_code[0];
      m_tag_ff.fault_code <= in_payload.raw_code[0] ? in_payload.fault_status : 8'd0;
      m_prod_ff           <= PROD_W'(in_payload.raw_code[15:1]) * PROD_W'(ref_res);

      o_valid_ff <= m_valid_ff;
      o_tag_ff   <= m_tag_ff;
      o_num_ff   <= {m_prod_ff, 15'd0};
      o_ovf_ff   <= DIV_W'({m_prod_ff, 15'd0}) >= (DIV_W'(nom_res) << QUOT_W);

      d_valid_ff[0] <= o_valid_ff;
      d_tag_ff[0]   <= o_tag_ff;
      d_ovf_ff[0]   <= o_ovf_ff;
      d_rem_ff[0]   <= o_num_ff;
      d_q_ff[0]     <= '0;
      for (int s = 0; s < QUOT_W; s++) begin
         d_valid_ff[s+1] <= d_valid_ff[s];
         d_tag_ff[s+1]   <= d_tag_ff[s];
         d_ovf_ff[s+1]   <= d_ovf_ff[s];
         d_rem_ff[s+1]   <= d_rem_in[s];
         d_q_ff[s+1]     <= d_q_in[s];
      end

      x_ff.valid <= d_valid_ff[QUOT_W];
      x_ff.tag   <= d_tag_ff[QUOT_W];
      x_ff.xq    <= xq_in;

      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         for (int s = 0; s <= QUOT_W; s++) begin
            d_valid_ff[s] <= 1'b0;
         end
         x_ff.valid <= 1'b0;
      end
   end

   assign x_out = x_ff;

endmodule

// ===== hdl/rtdc_cvd_sqrt.sv =====
module rtdc_cvd_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  rtdc_pkg::x_stage_type x_in,
   output rtdc_pkg::u_stage_type u_out
);
   import rtdc_pkg::*;

   x_stage_type        p_ff;
   logic signed [59:0] p_prod_ff;
   x_stage_type        r_ff;
   logic [RAD_W-1:0]   r_rad_ff;
   logic signed [61:0] rad_s;
   // one root bit per stage
   x_stage_type        s_ff      [ROOT_W+1];
   logic [RAD_W-1:0]   s_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]  s_root_ff [ROOT_W+1];
   logic [RAD_W-1:0]   s_rem_in  [ROOT_W];
   logic [ROOT_W-1:0]  s_root_in [ROOT_W];
   u_stage_type        u_ff;

   assign rad_s = $signed(62'(CVD_P2)) - 62'(p_prod_ff);

   always_comb begin
      for (int s = 0; s < ROOT_W; s++) begin
         logic [RAD_W:0] trial;
         trial = ((RAD_W+1)'(s_root_ff[s]) << (ROOT_W - s))
               + ((RAD_W+1)'(1) << (2 * (ROOT_W - 1 - s)));
         if ((RAD_W+1)'(s_rem_ff[s]) >= trial) begin
            s_rem_in[s]  = RAD_W'((RAD_W+1)'(s_rem_ff[s]) - trial);
            s_root_in[s] = s_root_ff[s] | (ROOT_W'(1) << (ROOT_W - 1 - s));
         end else begin
            s_rem_in[s]  = s_rem_ff[s];
            s_root_in[s] = s_root_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= x_in;
      p_prod_ff <= 60'(CVD_C) * 60'($signed({2'b00, x_in.xq}) - $signed({2'b00, X_ONE}));

      r_ff     <= p_ff;
      r_rad_ff <= rad_s[61] ? '0 : RAD_W'(rad_s);

      s_ff[0]      <= r_ff;
      s_rem_ff[0]  <= r_rad_ff;
      s_root_ff[0] <= '0;
      for (int s = 0; s < ROOT_W; s++) begin
         s_ff[s+1]      <= s_ff[s];
         s_rem_ff[s+1]  <= s_rem_in[s];
         s_root_ff[s+1] <= s_root_in[s];
      end

      u_ff.valid <= s_ff[ROOT_W].valid;
      u_ff.tag   <= s_ff[ROOT_W].tag;
      u_ff.xq    <= s_ff[ROOT_W].xq;
      u_ff.u     <= U_W'(CVD_P) - $signed(U_W'(s_root_ff[ROOT_W]));

      if (reset) begin
         p_ff.valid <= 1'b0;
         r_ff.valid <= 1'b0;
         for (int s = 0; s <= ROOT_W; s++) begin
            s_ff[s].valid <= 1'b0;
         end
         u_ff.valid <= 1'b0;
      end
   end

   assign u_out = u_ff;

endmodule

// ===== hdl/rtdc_poly.sv =====
module rtdc_poly (
   input  logic                  clock,
   input  logic                  reset,
   input  rtdc_pkg::u_stage_type u_in,
   output rtdc_pkg::h_stage_type h_out
);
   import rtdc_pkg::*;

   // per Horner step: multiply stage then round/add stage
   u_stage_type              mul_ff  [POLY_N];
   logic signed [H_W+XS_W:0] prod_ff [POLY_N];
   u_stage_type              acc_ff  [POLY_N];
   logic signed [H_W-1:0]    h_ff    [POLY_N];
   logic signed [H_W-1:0]    h_src   [POLY_N];
   h_stage_type              out_ff;

   always_comb begin
      h_src[0] = POLY_C5;
      for (int j = 1; j < POLY_N; j++) begin
         h_src[j] = h_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < POLY_N; j++) begin
         mul_ff[j]  <= (j == 0) ? u_in : acc_ff[j-1];
         prod_ff[j] <= (H_W+XS_W+1)'(h_src[j])
                     * (H_W+XS_W+1)'($signed({1'b0, ((j == 0) ? u_in.xq[XS_W-1:0]
                                                   : acc_ff[j-1].xq[XS_W-1:0])}));
         acc_ff[j]  <= mul_ff[j];
         h_ff[j]    <= poly_coef(j) + H_W'(round_shr(RW'(prod_ff[j]), 30));
      end
      out_ff.valid <= acc_ff[POLY_N-1].valid;
      out_ff.tag   <= acc_ff[POLY_N-1].tag;
      out_ff.u     <= acc_ff[POLY_N-1].u;
      out_ff.h     <= h_ff[POLY_N-1];
      if (reset) begin
         for (int j = 0; j < POLY_N; j++) begin
            mul_ff[j].valid <= 1'b0;
            acc_ff[j].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end
   end

   assign h_out = out_ff;

endmodule
